// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the converter RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/itpc_pkg.sv =====
// Shared types, constants and the operator precedence table of the converter.
// No dependencies; every RTL module of the converter imports this package.
`default_nettype none

package itpc_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int REF_BITS    = 16;
	localparam int CODE_W      = 6;
	localparam int CMD_W       = 2;
	localparam int PREC_W      = 5;
	localparam int NUM_KNOWN   = 43;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W       = $clog2(STACK_DEPTH);
	localparam int IN_DATA_W   = ((CODE_W + REF_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((1 + CODE_W + REF_BITS + 7) / 8) * 8;

	localparam logic [CODE_W-1:0] CODE_LPAREN = CODE_W'(0);
	localparam logic [CODE_W-1:0] CODE_RPAREN = CODE_W'(1);

	localparam logic [CMD_W-1:0] CMD_OPERAND  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_OPERATOR = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_END      = CMD_W'(2);

	// Precedence of each known operator code; XOR ranks below OR.
	localparam logic [PREC_W-1:0] PREC_TABLE [NUM_KNOWN] = '{
		5'd17, 5'd17, 5'd15, 5'd16, 5'd16, 5'd16, 5'd14, 5'd14, 5'd14, 5'd14,
		5'd13, 5'd13, 5'd12, 5'd12, 5'd11, 5'd9,  5'd10, 5'd8,  5'd8,  5'd8,
		5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd7,  5'd6,  5'd5,  5'd4,  5'd3,
		5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd3,
		5'd3,  5'd3,  5'd2
	};

	// Token classes produced by the front end.
	typedef enum logic [2:0] {
		K_OPERAND,
		K_LPAREN,
		K_RPAREN,
		K_OPER,
		K_FLUSH,
		K_IGNORE
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [CODE_W-1:0]   code;
		logic [PREC_W-1:0]   prec;
		logic                right_assoc;
		logic [REF_BITS-1:0] opnd;
	} tok_t;

	typedef struct packed {
		logic                is_op;
		logic [CODE_W-1:0]   code;
		logic [REF_BITS-1:0] opnd;
		logic                err;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
	} back_stat_t;

	// Unknown codes have precedence zero.
	function automatic logic [PREC_W-1:0] prec_of(input logic [CODE_W-1:0] code);
		logic [PREC_W-1:0] p;
		p = '0;
		if (code < CODE_W'(NUM_KNOWN)) begin
			p = PREC_TABLE[code];
		end
		return p;
	endfunction

	// Power, the unary operators, logical not, the conditional and the
	// assignments associate right; everything else associates left.
	function automatic logic right_of(input logic [CODE_W-1:0] code);
		return (code >= CODE_W'(2) && code <= CODE_W'(5)) || code == CODE_W'(25) ||
			(code >= CODE_W'(28) && code <= CODE_W'(41));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itpc_front.sv =====
// Input stage of the converter: registers each accepted word and classifies it.
// Depends on itpc_pkg for the token type and the precedence table.
`default_nettype none

module itpc_front
	import itpc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic [CMD_W-1:0]     s_tuser,
	output logic                      tok_valid,
	input  wire logic                 tok_ready,
	output tok_t                      tok
);

	logic [CODE_W-1:0]   in_code;
	logic [REF_BITS-1:0] in_opnd;
	tok_t                cls;
	tok_t                tok_s1;
	logic                vld_s1;

	assign in_code = s_tdata[CODE_W-1:0];
	assign in_opnd = s_tdata[CODE_W +: REF_BITS];

	// Sort the word into one of the token classes the back end handles.
	always_comb begin
		cls.code        = in_code;
		cls.prec        = prec_of(in_code);
		cls.right_assoc = right_of(in_code);
		cls.opnd        = in_opnd;
		case (s_tuser)
			CMD_OPERAND: begin
				cls.kind = K_OPERAND;
			end
			CMD_OPERATOR: begin
				if (in_code == CODE_LPAREN) begin
					cls.kind = K_LPAREN;
				end else if (in_code == CODE_RPAREN) begin
					cls.kind = K_RPAREN;
				end else begin
					cls.kind = K_OPER;
				end
			end
			CMD_END: begin
				cls.kind = K_FLUSH;
			end
			default: begin
				cls.kind = K_IGNORE;
			end
		endcase
	end

	assign s_tready  = !vld_s1 || tok_ready;
	assign tok_valid = vld_s1;
	assign tok       = tok_s1;

	// The stage register refills or empties when it is free or the queue takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tok_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/itpc_queue.sv =====
// Two-entry token queue between the front end and the stack engine.
// Depends on itpc_pkg for the token type.
`default_nettype none

module itpc_queue
	import itpc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire tok_t in_tok,
	output logic      out_valid,
	input  wire logic out_ready,
	output tok_t      out_tok
);

	tok_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       do_push;
	logic       do_pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_tok   = ent_q[rd_q];
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_valid && out_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= in_tok;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/itpc_back.sv =====
// Stack engine of the converter: runs the operator stack, at most one pop or
// push per cycle, and drives the output stream. Depends on itpc_pkg.
`default_nettype none

module itpc_back
	import itpc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tok_valid,
	output logic                       tok_ready,
	input  wire tok_t                  tok,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser,
	output back_stat_t                 stat
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RPAR  = 4'b0010,
		ST_OPER  = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t            state_q;
	state_t            state_d;
	tok_t              cur_q;
	logic [CODE_W-1:0] mem [STACK_DEPTH];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_m3;
	logic [CODE_W-1:0] top_q;
	logic [CODE_W-1:0] nxt_q;
	logic              full;
	logic              empty;
	logic [PREC_W-1:0] top_prec;
	logic              top_wins;

	logic              gen;
	logic              fin;
	logic              push;
	logic              pop;
	logic              take;
	logic              latch;
	logic [CODE_W-1:0] push_code;
	res_t              res;

	logic              pv_q;
	logic              plast_q;
	res_t              pres_q;
	logic              ov_q;
	logic              olast_q;
	res_t              ores_q;
	logic              o_free;
	logic              step_ok;
	logic              p_move;

	assign full     = cnt_q == CNT_W'(STACK_DEPTH);
	assign empty    = cnt_q == '0;
	assign cnt_m3   = cnt_q - CNT_W'(3);
	assign top_prec = prec_of(top_q);
	assign top_wins = cur_q.right_assoc ? (top_prec > cur_q.prec) : (top_prec >= cur_q.prec);

	// A result may be produced when the pending slot is free or can move on.
	assign o_free  = !ov_q || m_tready;
	assign step_ok = !pv_q || o_free;
	assign p_move  = pv_q && o_free && (plast_q || gen);

	// Sequencer: at most one stack action per cycle.
	always_comb begin
		state_d   = state_q;
		gen       = 1'b0;
		fin       = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		take      = 1'b0;
		latch     = 1'b0;
		push_code = cur_q.code;
		res.is_op = 1'b1;
		res.code  = top_q;
		res.opnd  = '0;
		res.err   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				push_code = tok.code;
				if (tok_valid) begin
					case (tok.kind)
						K_OPERAND: begin
							res.is_op = 1'b0;
							res.code  = '0;
							res.opnd  = tok.opnd;
							if (step_ok) begin
								take = 1'b1;
								gen  = 1'b1;
								fin  = 1'b1;
							end
						end
						K_LPAREN: begin
							res.code = tok.code;
							res.err  = 1'b1;
							if (full) begin
								if (step_ok) begin
									take = 1'b1;
									gen  = 1'b1;
									fin  = 1'b1;
								end
							end else begin
								take = 1'b1;
								push = 1'b1;
								fin  = 1'b1;
							end
						end
						K_RPAREN: begin
							take    = 1'b1;
							latch   = 1'b1;
							state_d = ST_RPAR;
						end
						K_OPER: begin
							take    = 1'b1;
							latch   = 1'b1;
							state_d = ST_OPER;
						end
						K_FLUSH: begin
							take    = 1'b1;
							state_d = ST_FLUSH;
						end
						default: begin
							take = 1'b1;
							fin  = 1'b1;
						end
					endcase
				end
			end
			ST_RPAR: begin
				// Pop down to the nearest left paren, which is dropped.
				if (empty) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if (top_q == CODE_LPAREN) begin
					pop     = 1'b1;
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if (step_ok) begin
					gen = 1'b1;
					pop = 1'b1;
				end
			end
			ST_OPER: begin
				// Pop tighter ops (equal too if left-assoc); then push, or flag overflow.
				if (!empty && top_q != CODE_LPAREN && top_wins) begin
					if (step_ok) begin
						gen = 1'b1;
						pop = 1'b1;
					end
				end else if (full) begin
					res.code = cur_q.code;
					res.err  = 1'b1;
					if (step_ok) begin
						gen     = 1'b1;
						fin     = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					push    = 1'b1;
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				// Everything on the stack leaves, left parens included.
				if (empty) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if (step_ok) begin
					gen = 1'b1;
					pop = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign tok_ready = take;

	// Control state: sequencer, stack fill, pending and output valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pv_q    <= 1'b0;
			plast_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (gen) begin
				pv_q    <= 1'b1;
				plast_q <= fin;
			end else if (p_move) begin
				pv_q <= 1'b0;
			end else if (fin) begin
				plast_q <= 1'b1;
			end
			if (p_move) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Stack memory with the top two entries mirrored in registers.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[cnt_q[IDX_W-1:0]] <= push_code;
			top_q                 <= push_code;
			nxt_q                 <= top_q;
		end else if (pop) begin
			top_q <= nxt_q;
			nxt_q <= mem[cnt_m3[IDX_W-1:0]];
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (latch) begin
			cur_q <= tok;
		end
		if (gen) begin
			pres_q <= res;
		end
		if (p_move) begin
			ores_q  <= pres_q;
			olast_q <= plast_q;
		end
	end

	assign m_tvalid   = ov_q;
	assign m_tdata    = OUT_DATA_W'({ores_q.opnd, ores_q.code, ores_q.is_op});
	assign m_tlast    = olast_q;
	assign m_tuser    = ores_q.err;
	assign stat.count = cnt_q;

endmodule

`default_nettype wire

// ===== rtl/core/infix_to_postfix_converter.sv =====
// Infix to postfix converter, top level.
// Channels: the slave side takes one infix token per word. tuser[1:0] is the
// token kind (operand, operator, end of expression). The master side gives
// one postfix token per word, and tlast marks the last word caused by an
// input token; tuser flags an operator push that found the stack full.
// Stack engine: an operand or a left paren is handled in the idle state. A
// right paren, an operator or an end of expression moves on to a state of
// its own that pops operators and then pushes or returns to idle, since the
// operator stack pops or pushes at most once per cycle.
// A word passes the input register, the queue, the pending register and the
// output register before it is presented on the master side, and it is held
// in the pending register until the next word of the same token or the end
// of that token is known, so that tlast can be set.
// Reset empties the stack and all queues; no clearing pass is needed.
// When the receiver stalls, the output register, the pending register,
// the two-entry queue and the input register fill in turn before s_tready
// drops.
`default_nettype none
`include "assert_macros.svh"

module infix_to_postfix_converter
	import itpc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// Fields from bit 0: operator_code, operand_ref, zero fill.
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// Fields from bit 0: cmd.
	input  wire logic [CMD_W-1:0]      s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// Fields from bit 0: out_is_operator, out_operator, out_operand, zero fill.
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// Field: out_last.
	output logic                       m_tlast,
	// Field: overflow_error.
	output logic                       m_tuser
);

	tok_t       f_tok;
	logic       f_valid;
	logic       f_ready;
	tok_t       q_tok;
	logic       q_valid;
	logic       q_ready;
	back_stat_t stat;

	itpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	itpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_tok    (f_tok),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_tok   (q_tok)
	);

	itpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.stat      (stat)
	);

	// The stack never holds more than its depth.
	`ASSERT_IMP(a_count_bound, 1'b1, stat.count <= CNT_W'(STACK_DEPTH), "stack count beyond depth")

	// The stack moves by at most one entry per cycle.
	`ASSERT_NXT(a_count_step, 1'b1,
		stat.count == $past(stat.count) || stat.count == $past(stat.count) + CNT_W'(1) ||
		stat.count == $past(stat.count) - CNT_W'(1), "stack count jumped")

	// An overflow report is an operator word and closes its token.
	`ASSERT_IMP(a_ovf_word, m_tvalid && m_tuser, m_tdata[0] && m_tlast, "bad overflow word")

endmodule

`default_nettype wire

// ===== verif/infix_to_postfix_converter_test.sv =====
// Self-checking testbench for the infix to postfix converter.
// It streams infix tokens into the block, predicts the postfix words with its own shunting-yard
// model and compares every output word. Depends on itpc_pkg and the converter RTL.

module infix_to_postfix_converter_test;
	import itpc_pkg::*;

	localparam int LIMIT       = 400000;
	localparam int ITEM_TARGET = 460;
	localparam int MAX_REPORTS = 10;

	// Token kind the block ignores.
	localparam logic [CMD_W-1:0] CMD_IGNORED = CMD_W'(3);

	// Operator codes used by name in the directed part and the expression builder.
	localparam logic [CODE_W-1:0] OP_POWER  = CODE_W'(2);
	localparam logic [CODE_W-1:0] OP_UPLUS  = CODE_W'(3);
	localparam logic [CODE_W-1:0] OP_INVERT = CODE_W'(5);
	localparam logic [CODE_W-1:0] OP_MUL    = CODE_W'(6);
	localparam logic [CODE_W-1:0] OP_ADD    = CODE_W'(10);
	localparam logic [CODE_W-1:0] OP_XOR    = CODE_W'(15);
	localparam logic [CODE_W-1:0] OP_OR     = CODE_W'(16);
	localparam logic [CODE_W-1:0] OP_LNOT   = CODE_W'(25);
	localparam logic [CODE_W-1:0] OP_COMMA  = CODE_W'(42);
	localparam logic [CODE_W-1:0] OP_MAX    = CODE_W'(47);

	// Precedence by operator code; codes past the comma rank zero.
	localparam int RANK [0:42] = '{
		17, 17, 15, 16, 16, 16, 14, 14, 14, 14,
		13, 13, 12, 12, 11, 9, 10, 8, 8, 8,
		8, 8, 8, 8, 8, 7, 6, 5, 4, 3,
		3, 3, 3, 3, 3, 3, 3, 3, 3, 3,
		3, 3, 2
	};
	// Bit n set where code n associates right: power, unary ops, logical not,
	// the conditional and the assignments.
	localparam bit [42:0] RIGHT_MASK = 43'h3FFF200003C;

	typedef struct {
		logic [CMD_W-1:0]    cmd;
		logic [CODE_W-1:0]   code;
		logic [REF_BITS-1:0] opnd;
		bit                  drain;
	} token_t;

	typedef struct {
		logic                is_op;
		logic [CODE_W-1:0]   code;
		logic [REF_BITS-1:0] opnd;
		logic                last;
		logic                err;
	} postfix_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [CMD_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	token_t   token_queue[$];
	postfix_t postfix_expected[$];

	// Own copy of the operator stack.
	logic [CODE_W-1:0] op_stack [STACK_DEPTH];
	int                op_depth = 0;

	int     built_items = 0;
	bit     hold_next = 1'b0;
	int     words_sent = 0;
	int     words_seen = 0;
	int     send_gap = 0;
	int     recv_stall = 0;
	int     mismatches = 0;
	int     cycles = 0;
	token_t sent_tok;

	infix_to_postfix_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rank_of(input logic [CODE_W-1:0] code);
		return (code <= OP_COMMA) ? RANK[code] : 0;
	endfunction

	function automatic bit binds_right(input logic [CODE_W-1:0] code);
		return (code <= OP_COMMA) ? RIGHT_MASK[code] : 1'b0;
	endfunction

	task automatic add_postfix(input logic is_op, input logic [CODE_W-1:0] code,
			input logic [REF_BITS-1:0] opnd, input logic err);
		postfix_t p;
		p.is_op = is_op;
		p.code  = code;
		p.opnd  = opnd;
		p.last  = 1'b0;
		p.err   = err;
		postfix_expected.push_back(p);
	endtask

	task automatic push_operator(input logic [CODE_W-1:0] code);
		if (op_depth >= STACK_DEPTH) begin
			add_postfix(1'b1, code, '0, 1'b1);
		end else begin
			op_stack[op_depth] = code;
			op_depth++;
		end
	endtask

	// Shunting-yard step for one accepted token; queues the words it causes.
	task automatic convert_token(input token_t t);
		int                first;
		bit                done;
		logic [CODE_W-1:0] top;
		postfix_t          p;
		first = postfix_expected.size();
		done = 1'b0;
		case (t.cmd)
			CMD_OPERAND: begin
				add_postfix(1'b0, '0, t.opnd, 1'b0);
			end
			CMD_OPERATOR: begin
				if (t.code == CODE_LPAREN) begin
					push_operator(t.code);
				end else if (t.code == CODE_RPAREN) begin
					// Pop down to the nearest left paren, which is dropped.
					while (op_depth > 0 && !done) begin
						op_depth--;
						top = op_stack[op_depth];
						if (top == CODE_LPAREN) begin
							done = 1'b1;
						end else begin
							add_postfix(1'b1, top, '0, 1'b0);
						end
					end
				end else begin
					// Pop while the top binds more tightly, or as tightly for a left-assoc token, then push.
					while (op_depth > 0 && !done) begin
						top = op_stack[op_depth-1];
						if (top == CODE_LPAREN) begin
							done = 1'b1;
						end else if (binds_right(t.code) ? rank_of(top) <= rank_of(t.code)
								: rank_of(top) < rank_of(t.code)) begin
							done = 1'b1;
						end else begin
							op_depth--;
							add_postfix(1'b1, top, '0, 1'b0);
						end
					end
					push_operator(t.code);
				end
			end
			CMD_END: begin
				while (op_depth > 0) begin
					op_depth--;
					add_postfix(1'b1, op_stack[op_depth], '0, 1'b0);
				end
			end
			default: begin
			end
		endcase
		if (postfix_expected.size() > first) begin
			p = postfix_expected[postfix_expected.size()-1];
			p.last = 1'b1;
			postfix_expected[postfix_expected.size()-1] = p;
		end
	endtask

	task automatic add_token(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code);
		token_t t;
		t.cmd   = cmd;
		t.code  = code;
		t.opnd  = REF_BITS'($urandom);
		t.drain = hold_next;
		hold_next = 1'b0;
		token_queue.push_back(t);
		if (cmd != CMD_IGNORED) begin
			built_items++;
		end
	endtask

	task automatic add_operand(input logic [REF_BITS-1:0] opnd);
		add_token(CMD_OPERAND, CODE_W'($urandom_range(0, OP_MAX)));
		token_queue[token_queue.size()-1].opnd = opnd;
	endtask

	// Expression with random nesting, unary ops and binary ops; may leave stray left parens.
	task automatic build_expression();
		int terms;
		int open;
		int closes;
		terms = $urandom_range(1, 7);
		open = 0;
		for (int i = 0; i < terms; i++) begin
			while (open < 6 && $urandom_range(0, 3) == 0) begin
				add_token(CMD_OPERATOR, CODE_LPAREN);
				open++;
			end
			if ($urandom_range(0, 4) == 0) begin
				add_token(CMD_OPERATOR, ($urandom_range(0, 3) == 0) ? OP_LNOT
					: CODE_W'($urandom_range(OP_UPLUS, OP_INVERT)));
			end
			add_operand(REF_BITS'($urandom));
			closes = (open > 0) ? $urandom_range(0, open) : 0;
			for (int c = 0; c < closes; c++) begin
				add_token(CMD_OPERATOR, CODE_RPAREN);
				open--;
			end
			if (i < terms - 1) begin
				add_token(CMD_OPERATOR, CODE_W'($urandom_range(OP_POWER, OP_MAX)));
			end
		end
		// Usually close what is open; sometimes leave stray left parens.
		if ($urandom_range(0, 3) != 0) begin
			while (open > 0) begin
				add_token(CMD_OPERATOR, CODE_RPAREN);
				open--;
			end
		end
		add_token(CMD_END, CODE_W'($urandom_range(0, OP_MAX)));
	endtask

	// Long chain of left parens and powers that nothing pops, so the stack may overflow.
	task automatic build_deep_nest();
		int depth;
		depth = $urandom_range(24, 40);
		for (int i = 0; i < depth; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				add_token(CMD_OPERATOR, CODE_LPAREN);
			end else begin
				add_token(CMD_OPERATOR, OP_POWER);
				if ($urandom_range(0, 2) == 0) begin
					add_operand(REF_BITS'($urandom));
				end
			end
		end
		add_token(CMD_END, '0);
	endtask

	task automatic build_noise();
		int n;
		n = $urandom_range(4, 14);
		for (int i = 0; i < n; i++) begin
			add_token(CMD_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, OP_MAX)));
		end
	endtask

	// Sender: presents the head of the token queue and predicts on acceptance.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				sent_tok = token_queue.pop_front();
				convert_token(sent_tok);
				words_sent++;
				send_gap = ((words_sent / 64) % 4 == 0) ? 0 : $urandom_range(0, 3);
			end
			if (s_tvalid && !s_tready) begin
				// Hold the word until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (token_queue.size() != 0 &&
					!(token_queue[0].drain && postfix_expected.size() != 0)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= IN_DATA_W'({token_queue[0].opnd, token_queue[0].code});
				s_tuser  <= token_queue[0].cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls and comparison against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				words_seen++;
				if (postfix_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("unexpected word: data=%h last=%0d err=%0d",
							m_tdata, m_tlast, m_tuser);
					end
				end else begin
					postfix_t e;
					e = postfix_expected.pop_front();
					if (m_tdata[0] !== e.is_op || m_tdata[CODE_W:1] !== e.code ||
							m_tdata[CODE_W+REF_BITS:CODE_W+1] !== e.opnd ||
							m_tlast !== e.last || m_tuser !== e.err) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("mismatch: expected op=%0d code=%0d opnd=%h last=%0d err=%0d",
								e.is_op, e.code, e.opnd, e.last, e.err);
							$display("          actual   op=%0d code=%0d opnd=%h last=%0d err=%0d",
								m_tdata[0], m_tdata[CODE_W:1],
								m_tdata[CODE_W+REF_BITS:CODE_W+1], m_tlast, m_tuser);
						end
					end
				end
				recv_stall = ((words_seen / 64) % 4 == 1) ? 0 : $urandom_range(0, 3);
			end else if (recv_stall > 0) begin
				recv_stall--;
			end
			m_tready <= (recv_stall == 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int kind;

		// Directed: operand extremes, empty flushes, a right paren with no
		// left paren, XOR below OR, right-assoc power, stray left parens,
		// an unknown code and an ignored kind.
		add_operand('0);
		add_operand('1);
		add_token(CMD_END, '0);
		add_token(CMD_OPERATOR, CODE_RPAREN);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, OP_ADD);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, OP_MUL);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, CODE_RPAREN);
		add_token(CMD_END, OP_MAX);
		add_token(CMD_OPERATOR, CODE_LPAREN);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, OP_XOR);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, OP_OR);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, CODE_RPAREN);
		add_token(CMD_OPERATOR, OP_POWER);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, OP_POWER);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_END, '0);
		add_token(CMD_OPERATOR, CODE_LPAREN);
		add_token(CMD_OPERATOR, OP_MAX);
		add_token(CMD_IGNORED, OP_MAX);
		add_operand(REF_BITS'($urandom));
		add_token(CMD_OPERATOR, OP_COMMA);
		add_token(CMD_END, '0);

		// Random part; the first sequence waits for the output to drain.
		hold_next = 1'b1;
		while (built_items < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0) begin
				hold_next = 1'b1;
			end
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				build_expression();
			end else if (kind < 16) begin
				build_deep_nest();
			end else begin
				build_noise();
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (token_queue.size() != 0) begin
			@(posedge clk);
		end
		while (postfix_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		if (mismatches == 0 && postfix_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== infix_to_postfix_converter.f =====
+incdir+rtl/core
rtl/core/itpc_pkg.sv
rtl/core/itpc_front.sv
rtl/core/itpc_queue.sv
rtl/core/itpc_back.sv
rtl/core/infix_to_postfix_converter.sv
verif/infix_to_postfix_converter_test.sv
